FILE: design/fcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// fcw_pkg: shared types and constants for the fat12 cluster chain walker
// used by fcw_ctrl, fcw_dpath and the top level; no dependencies

package fcw_pkg;

  localparam logic       CMD_LOAD   = 1'b0;
  localparam logic       CMD_WALK   = 1'b1;

  localparam logic       REG_DATA_START = 1'b0;
  localparam logic       REG_SPC        = 1'b1;

  localparam logic [11:0] FIRST_DATA = 12'd2;
  localparam logic [11:0] END_MARK   = 12'hFF8;

  localparam logic [15:0] DATA_START_RST = 16'd33;
  localparam logic [7:0]  SPC_RST        = 8'd1;

  typedef enum logic [1:0] {
    ST_CONT  = 2'd0,
    ST_END   = 2'd1,
    ST_TRUNC = 2'd2,
    ST_BAD   = 2'd3
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic load_we;   // write the input byte into the table
    logic start;     // take the first cluster of a walk
    logic rd_lo;     // read low entry byte, form the sector address
    logic rd_hi;     // read high entry byte, hold the low one
    logic cap;       // form the result from both bytes
    logic advance;   // step to the next cluster
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad;       // current cluster is out of range
    logic res_last;  // held result ends the walk
  } dpath_stat_t;

endpackage

`default_nettype wire

FILE: design/fcw_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// fcw_ram: generic single write port, single read port ram with registered read
// no dependencies

module fcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/fcw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// fcw_ctrl: state machine sequencing loads and chain walks
// depends on fcw_pkg

module fcw_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_cmd_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  input  wire fcw_pkg::dpath_stat_t stat_i,
  output fcw_pkg::ctrl_cmd_t       cmd_o
);

  import fcw_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RD_LO = 5'b00010,
    S_RD_HI = 5'b00100,
    S_CAP   = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   in_acc;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign in_acc      = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_cmd_i == CMD_WALK) begin
            cmd_o.start = 1'b1;
            state_d     = S_RD_LO;
          end else begin
            cmd_o.load_we = 1'b1;
          end
        end
      end
      S_RD_LO: begin
        cmd_o.rd_lo = 1'b1;
        state_d     = stat_i.bad ? S_OUT : S_RD_HI;
      end
      S_RD_HI: begin
        cmd_o.rd_hi = 1'b1;
        state_d     = S_CAP;
      end
      S_CAP: begin
        cmd_o.cap = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          if (stat_i.res_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = S_RD_LO;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/fcw_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// fcw_dpath: table store, config registers, entry extraction and result registers
// depends on fcw_pkg and fcw_ram

module fcw_dpath #(
  parameter int TABLE_BYTES = 8192,
  parameter int MAX_RUN     = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_index_i,
  input  wire logic [15:0]         cfg_wdata_i,
  input  wire logic [12:0]         table_address_i,
  input  wire logic [7:0]          table_byte_i,
  input  wire logic [11:0]         start_cluster_i,
  input  wire fcw_pkg::ctrl_cmd_t  cmd_i,
  output fcw_pkg::dpath_stat_t     stat_o,
  output logic [11:0]              cluster_o,
  output logic [19:0]              sector_address_o,
  output logic [11:0]              next_cluster_o,
  output logic [1:0]               status_o,
  output logic                     last_o
);

  import fcw_pkg::*;

  localparam int          AW = $clog2(TABLE_BYTES);
  localparam int          CW = $clog2(MAX_RUN + 1);
  localparam logic [13:0] TB = 14'(TABLE_BYTES);
  localparam logic [CW-1:0] CNT_LAST = CW'(MAX_RUN - 1);

  logic [15:0]   data_start_q;
  logic [7:0]    spc_q;
  logic [11:0]   cur_q;
  logic [CW-1:0] cnt_q;
  logic [7:0]    lo_q;
  logic [19:0]   sec_q;
  logic [11:0]   nxt_q;
  status_e       status_q;
  logic          last_q;

  logic [13:0]   cur_x3;
  logic [12:0]   idx;
  logic [13:0]   idx_p1;
  logic          bad;
  logic          load_ok;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  logic [15:0]   word;
  logic [11:0]   entry;
  logic [11:0]   cur_m2;
  logic [19:0]   sec_calc;

  // byte offset of the entry is cluster * 3 / 2
  assign cur_x3  = {2'b00, cur_q} + {1'b0, cur_q, 1'b0};
  assign idx     = cur_x3[13:1];
  assign idx_p1  = {1'b0, idx} + 14'd1;
  assign bad     = (cur_q < FIRST_DATA) || (idx_p1 >= TB);
  assign load_ok = cmd_i.load_we && ({1'b0, table_address_i} < TB);
  assign raddr   = cmd_i.rd_hi ? idx_p1[AW-1:0] : idx[AW-1:0];

  fcw_ram #(
    .WIDTH (8),
    .DEPTH (TABLE_BYTES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (load_ok),
    .waddr_i (table_address_i[AW-1:0]),
    .wdata_i (table_byte_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign word     = {rdata, lo_q};
  assign entry    = cur_q[0] ? word[15:4] : word[11:0];
  assign cur_m2   = cur_q - FIRST_DATA;
  assign sec_calc = {4'b0000, data_start_q} + (20'(cur_m2) * 20'(spc_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_start_q <= DATA_START_RST;
      spc_q        <= SPC_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_DATA_START: data_start_q <= cfg_wdata_i;
        REG_SPC:        spc_q        <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      last_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        cnt_q <= '0;
      end else if (cmd_i.advance) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (cmd_i.rd_lo && bad) begin
        last_q <= 1'b1;
      end else if (cmd_i.cap) begin
        last_q <= (entry >= END_MARK) || (cnt_q == CNT_LAST);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cur_q <= start_cluster_i;
    end else if (cmd_i.advance) begin
      cur_q <= nxt_q;
    end
    if (cmd_i.rd_lo) begin
      sec_q <= bad ? 20'd0 : sec_calc;
      if (bad) begin
        nxt_q    <= 12'd0;
        status_q <= ST_BAD;
      end
    end
    if (cmd_i.rd_hi) begin
      lo_q <= rdata;
    end
    if (cmd_i.cap) begin
      nxt_q <= entry;
      if (entry >= END_MARK) begin
        status_q <= ST_END;
      end else if (cnt_q == CNT_LAST) begin
        status_q <= ST_TRUNC;
      end else begin
        status_q <= ST_CONT;
      end
    end
  end

  assign stat_o.bad      = bad;
  assign stat_o.res_last = last_q;

  assign cluster_o        = cur_q;
  assign sector_address_o = sec_q;
  assign next_cluster_o   = nxt_q;
  assign status_o         = status_q;
  assign last_o           = last_q;

endmodule

`default_nettype wire

FILE: design/fat12_cluster_chain_walker.sv
`timescale 1ns / 1ps
`default_nettype none
// fat12 cluster chain walker: a load item writes its byte into the table as it is
// taken; a walk item gives one result per cluster, formed in the states rd_lo,
// rd_hi, cap and out (rd_lo then out for a bad cluster), since the single table
// read port takes two reads; no new item is taken while a walk is under way.
// reset restores data_start to 33 and sectors_per_cluster to 1; the table
// contents are undefined until loaded.

module fat12_cluster_chain_walker #(
  parameter int TABLE_BYTES = 8192,
  parameter int MAX_RUN     = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        cmd_i,
  input  wire logic [12:0] table_address_i,
  input  wire logic [7:0]  table_byte_i,
  input  wire logic [11:0] start_cluster_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [11:0]      cluster_o,
  output logic [19:0]      sector_address_o,
  output logic [11:0]      next_cluster_o,
  output logic [1:0]       status_o,
  output logic             last_o
);

  import fcw_pkg::*;

  ctrl_cmd_t   cmd;
  dpath_stat_t stat;

  fcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (cmd_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  fcw_dpath #(
    .TABLE_BYTES (TABLE_BYTES),
    .MAX_RUN     (MAX_RUN)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .table_address_i  (table_address_i),
    .table_byte_i     (table_byte_i),
    .start_cluster_i  (start_cluster_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cluster_o        (cluster_o),
    .sector_address_o (sector_address_o),
    .next_cluster_o   (next_cluster_o),
    .status_o         (status_o),
    .last_o           (last_o)
  );

endmodule

`default_nettype wire
